### rtl/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int NumChain  = 8;
    localparam int NumBlock  = 16;
    localparam int NumRounds = 64;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    // Control from the sequencer to the message schedule cells.
    typedef struct packed {
        logic       load;
        logic [3:0] load_idx;
        t_word      load_data;
        logic       shift;
    } t_sched_ctl;

    localparam t_word InitReset [NumChain] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage

### rtl/sha_sched_cell.sv
// One cell of the message schedule chain: holds a word, loads or takes its neighbor's.
`timescale 1ns / 1ps
module sha_sched_cell (
    input  logic         i_clk,
    input  logic         i_load,
    input  sha_pkg::t_word i_load_data,
    input  logic         i_shift,
    input  sha_pkg::t_word i_neighbor,
    output sha_pkg::t_word o_word
);
    import sha_pkg::*;

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_load_data;
        end else if (i_shift) begin
            r_word <= i_neighbor;
        end
    end

    assign o_word = r_word;
endmodule

### rtl/sha_sched.sv
// Message schedule: a row of sixteen cells that shift one word per round.
`timescale 1ns / 1ps
module sha_sched (
    input  logic               i_clk,
    input  sha_pkg::t_sched_ctl i_ctl,
    output sha_pkg::t_word     o_w
);
    import sha_pkg::*;

    t_word w_cell [NumBlock];
    t_word w_next;

    // Cell 0 holds w[t]; the new word enters at cell 15.
    assign w_next = w_cell[0] + ssig0(w_cell[1]) + w_cell[9] + ssig1(w_cell[14]);

    for (genvar g = 0; g < NumBlock; g++) begin : g_cell
        t_word w_nb;
        if (g == NumBlock - 1) begin : g_end
            assign w_nb = w_next;
        end else begin : g_mid
            assign w_nb = w_cell[g + 1];
        end
        sha_sched_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_ctl.load && (i_ctl.load_idx == 4'(g))),
            .i_load_data(i_ctl.load_data),
            .i_shift    (i_ctl.shift),
            .i_neighbor (w_nb),
            .o_word     (w_cell[g])
        );
    end

    assign o_w = w_cell[0];
endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: input framing, padding, round datapath, output.
//
// Usage: message words arrive on the input channel (i_valid/o_ready) as big-endian
// 32-bit beats with a byte count and an end flag. Every sixteenth word starts a
// 64-round compression, one round per cycle, followed by an add into the chain;
// o_ready stays low meanwhile. A word that does not fill a block is only stored.
// Throughput is set by the single round unit fed by the schedule cells: no new
// word is taken until a block's rounds and add are done.
// After the final beat one or two compressions run; the padding words are written
// one per cycle into the schedule cells before each block that holds them. Then
// eight digest beats go out on o_valid/i_ready, index 0 first, last_word on the
// eighth, once the last padded block has been added into the chain.
// If the receiver stalls, the current digest beat holds and no input is taken
// until all eight are delivered. After the digest the initial words reload.
// Reset (synchronous, active low) restores the standard SHA-256 initial words
// and an empty message. Configuration writes (i_cfg_valid/o_cfg_ready) are
// always taken; the 3-bit index reaches all eight initial words.
`timescale 1ns / 1ps
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sha_pkg::*;

    t_state     r_state, n_state;
    t_word      r_init [NumChain];
    t_word      r_chain [NumChain];
    t_word      r_v [NumChain];
    logic [3:0] r_fill;
    logic [63:0] r_bitlen;
    logic       r_in_msg;
    logic [5:0] r_round;
    logic [3:0] r_pad_idx;
    logic       r_pad_done;   // final beat taken, held until the digest is out
    logic       r_two;        // length block still to come after this compress
    logic [2:0] r_out_idx;
    logic       r_pad_first_flag;   // a standalone 0x80 word is still owed

    t_sched_ctl w_ctl;
    t_word      w_w;
    logic       w_acc;
    t_word      w_base [NumChain];
    t_word      w_t1, w_t2;
    logic [2:0] w_bc;
    t_word      w_last;
    logic [3:0] w_pad_first;

    assign o_cfg_ready = 1'b1;
    assign w_acc = i_valid && o_ready;

    // Chain base for a new message comes from the init words.
    always_comb begin
        for (int i = 0; i < NumChain; i++) begin
            w_base[i] = r_in_msg ? r_chain[i] : r_init[i];
        end
    end

    assign w_bc = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    // Final word with pad byte merged in, when it holds fewer than four bytes.
    always_comb begin
        case (w_bc)
            3'd0:    w_last = 32'h8000_0000;
            3'd1:    w_last = {i_data_word[31:24], 24'h80_0000};
            3'd2:    w_last = {i_data_word[31:16], 16'h8000};
            3'd3:    w_last = {i_data_word[31:8], 8'h80};
            default: w_last = i_data_word;
        endcase
    end

    // Pad words written after the final beat start here.
    assign w_pad_first = r_fill;

    assign w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                  + RoundK[r_round] + w_w;
    assign w_t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Pad word for the current pad slot.
    t_word w_pad_word;
    always_comb begin
        if (r_pad_idx == 4'(NumBlock - 2) && !r_two) begin
            w_pad_word = r_bitlen[63:32];
        end else if (r_pad_idx == 4'(NumBlock - 1) && !r_two) begin
            w_pad_word = r_bitlen[31:0];
        end else if (r_pad_idx == r_fill && r_pad_first_flag) begin
            w_pad_word = 32'h8000_0000;
        end else begin
            w_pad_word = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (r_fill == 4'(NumBlock - 1)) begin
                        // a full block runs at once; on a final beat the padding follows it
                        n_state = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   if (r_pad_idx == 4'(NumBlock - 1)) n_state = ST_ROUND;
            ST_ROUND: if (r_round == 6'(NumRounds - 1)) n_state = ST_ADD;
            ST_ADD: begin
                if (!r_pad_done) n_state = ST_IDLE;
                else if (r_two)  n_state = ST_PAD;
                else             n_state = ST_OUT;
            end
            ST_OUT:   if (i_ready && r_out_idx == 3'(NumChain - 1)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_OUT);
        o_digest_word = r_chain[r_out_idx];
        o_word_index = r_out_idx;
        o_last_word = (r_out_idx == 3'(NumChain - 1));
        w_ctl.load = 1'b0;
        w_ctl.load_idx = r_fill;
        w_ctl.load_data = i_data_word;
        w_ctl.shift = (r_state == ST_ROUND);
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    w_ctl.load = 1'b1;
                    w_ctl.load_data = i_end_of_message ? w_last : i_data_word;
                end
            end
            ST_PAD: begin
                w_ctl.load = (r_pad_idx >= w_pad_first);
                w_ctl.load_idx = r_pad_idx;
                w_ctl.load_data = w_pad_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_bitlen <= '0;
            r_in_msg <= 1'b0;
            r_round <= '0;
            r_pad_idx <= '0;
            r_pad_done <= 1'b0;
            r_two <= 1'b0;
            r_out_idx <= '0;
            r_pad_first_flag <= 1'b0;
            for (int i = 0; i < NumChain; i++) begin
                r_init[i] <= InitReset[i];
                r_chain[i] <= InitReset[i];
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_init[i_cfg_index] <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_in_msg <= 1'b1;
                        for (int i = 0; i < NumChain; i++) begin
                            r_chain[i] <= w_base[i];
                            r_v[i] <= w_base[i];
                        end
                        r_round <= '0;
                        if (!i_end_of_message) begin
                            r_bitlen <= r_bitlen + 64'd32;
                            r_fill <= r_fill + 4'd1;
                        end else begin
                            r_bitlen <= r_bitlen + 64'({w_bc, 3'b000});
                            r_pad_done <= 1'b1;
                            r_pad_idx <= '0;
                            if (w_bc == 3'd4) begin
                                // separate 0x80 word follows
                                r_pad_first_flag <= 1'b1;
                                r_fill <= r_fill + 4'd1;
                                r_two <= (r_fill >= 4'(NumBlock - 3));
                            end else begin
                                r_pad_first_flag <= 1'b0;
                                r_fill <= r_fill + 4'd1;
                                r_two <= (r_fill >= 4'(NumBlock - 2));
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_idx <= r_pad_idx + 4'd1;
                    if (r_pad_idx == 4'(NumBlock - 1)) begin
                        r_fill <= '0;
                        r_pad_first_flag <= 1'b0;
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                end
                ST_ADD: begin
                    for (int i = 0; i < NumChain; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                        r_v[i] <= r_chain[i] + r_v[i];
                    end
                    r_round <= '0;
                    r_fill <= '0;
                    r_pad_idx <= '0;
                    if (r_two) begin
                        // next block is zeros plus length, led by 0x80 if still owed
                        r_two <= 1'b0;
                    end
                    r_out_idx <= '0;
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'(NumChain - 1)) begin
                            r_pad_done <= 1'b0;
                            r_in_msg <= 1'b0;
                            r_bitlen <= '0;
                            r_fill <= '0;
                            for (int i = 0; i < NumChain; i++) begin
                                r_chain[i] <= r_init[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    sha_sched u_sched (
        .i_clk(i_clk),
        .i_ctl(w_ctl),
        .o_w  (w_w)
    );

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken during digest");
    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == 6'd63) |=> r_state == ST_ADD)
        else $error("round count overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_word_index))
        else $error("digest index moved under stall");
endmodule

### dv/sha256_stream_hasher_tb.sv
// Self-checking testbench for the SHA-256 stream hasher: random messages, configs and stalls.
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
    import sha_pkg::*;

    typedef struct {
        t_word      data;
        logic [2:0] count;
        logic       eom;
    } t_msg_beat;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    localparam int DrainCycles = 200;
    localparam int CycleLimit  = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    sha256_stream_hasher uut (.*);

    always #1 i_clk = ~i_clk;

    t_msg_beat    msg_pending[$];
    t_digest_beat digest_expected[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // Predictor state
    t_word       init_model[NumChain];
    t_word       chain_model[NumChain];
    t_word       block_model[NumBlock];
    int          fill_model;
    logic [63:0] bitlen_model;
    logic        in_msg_model;

    function automatic t_word ror32(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_model();
        t_word w[NumRounds];
        t_word v[NumChain];
        t_word t1, t2;
        for (int t = 0; t < NumBlock; t++) w[t] = block_model[t];
        for (int t = NumBlock; t < NumRounds; t++) begin
            w[t] = w[t-16] + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        for (int i = 0; i < NumChain; i++) v[i] = chain_model[i];
        for (int t = 0; t < NumRounds; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < NumChain; i++) chain_model[i] += v[i];
    endtask

    task automatic absorb_word(t_word data, logic [2:0] count, logic eom);
        int    nbytes;
        int    nxt;
        t_word keep;
        t_digest_beat d;
        if (!in_msg_model) begin
            chain_model = init_model;
            in_msg_model = 1'b1;
        end
        if (!eom) begin
            block_model[fill_model] = data;
            bitlen_model += 64'd32;
            fill_model++;
            if (fill_model == NumBlock) begin
                compress_model();
                fill_model = 0;
            end
            return;
        end
        nbytes = (count > 4) ? 4 : int'(count);
        bitlen_model += 64'(8 * nbytes);
        if (nbytes < 4) begin
            keep = (nbytes == 0) ? '0 : (32'hffffffff << (8 * (4 - nbytes)));
            block_model[fill_model] = (data & keep) | (32'h80 << (8 * (3 - nbytes)));
            nxt = fill_model + 1;
        end else begin
            block_model[fill_model] = data;
            nxt = fill_model + 1;
            if (nxt == NumBlock) begin
                compress_model();
                nxt = 0;
            end
            block_model[nxt] = 32'h80000000;
            nxt++;
        end
        // no room for the length: pad out and run an extra block
        if (nxt > NumBlock - 2) begin
            while (nxt < NumBlock) block_model[nxt++] = '0;
            compress_model();
            nxt = 0;
        end
        while (nxt < NumBlock - 2) block_model[nxt++] = '0;
        block_model[NumBlock-2] = bitlen_model[63:32];
        block_model[NumBlock-1] = bitlen_model[31:0];
        compress_model();
        for (int k = 0; k < NumChain; k++) begin
            d.word  = chain_model[k];
            d.index = 3'(k);
            d.last  = (k == NumChain - 1);
            digest_expected.push_back(d);
        end
        chain_model = init_model;
        fill_model = 0;
        bitlen_model = '0;
        in_msg_model = 1'b0;
    endtask

    // Predict on every accepted beat
    logic in_taken = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            init_model = InitReset;
            chain_model = InitReset;
            fill_model = 0;
            bitlen_model = '0;
            in_msg_model = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_word(i_data_word, i_byte_count, i_end_of_message);
                in_taken <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) init_model[i_cfg_index] = i_cfg_data;
        end
    end

    // Sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_msg_beat b;
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (msg_pending.size() > 0) begin
                b = msg_pending.pop_front();
                i_data_word <= b.data;
                i_byte_count <= b.count;
                i_end_of_message <= b.eom;
                i_valid <= 1'b1;
                in_taken <= 1'b0;
                burst_left--;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes now and then
    logic [15:0] stall_pattern = 16'hffff;
    always @(negedge i_clk) begin
        if (cycle_count % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'hffff;
                1: stall_pattern = 16'h0f0f;
                default: stall_pattern = 16'($urandom());
            endcase
            if (stall_pattern == '0) stall_pattern = 16'h0001;
        end
        i_ready <= stall_pattern[cycle_count % 16];
    end

    // Check every accepted digest beat
    always @(posedge i_clk) begin
        t_digest_beat d;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_expected.size() == 0) begin
                $error("unexpected digest beat: word %h index %0d", o_digest_word,
                       o_word_index);
                fail_count++;
            end else begin
                d = digest_expected.pop_front();
                if (o_digest_word !== d.word) begin
                    $error("digest_word: expected %h, got %h", d.word, o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== d.index) begin
                    $error("word_index: expected %0d, got %0d", d.index, o_word_index);
                    fail_count++;
                end
                if (o_last_word !== d.last) begin
                    $error("last_word: expected %0d, got %0d", d.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_beat(t_word data, int count, bit eom);
        t_msg_beat b;
        b.data = data;
        b.count = 3'(count);
        b.eom = eom;
        msg_pending.push_back(b);
    endtask

    task automatic push_message(int nwords, int last_count);
        for (int i = 0; i < nwords; i++) push_beat($urandom(), $urandom_range(0, 7), 1'b0);
        push_beat($urandom(), last_count, 1'b1);
    endtask

    task automatic write_init(int idx, t_word value);
        @(negedge i_clk);
        i_cfg_index <= 3'(idx);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every digest has come back and the block has settled
    task automatic drain();
        while (!(msg_pending.size() == 0 && !i_valid && digest_expected.size() == 0))
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, "abc", tails, odd counts, block edges, extreme words
        push_beat(32'h0, 0, 1'b1);
        push_beat(32'h61626300, 3, 1'b1);
        push_beat(32'hffffffff, 1, 1'b1);
        push_beat(32'hffffffff, 2, 1'b1);
        push_beat(32'h0, 4, 1'b1);
        push_beat(32'hffffffff, 5, 1'b1);
        push_beat(32'h12345678, 2, 1'b0);
        push_beat(32'hffffffff, 7, 1'b1);
        for (int i = 0; i < 13; i++) push_beat(32'hffffffff, 4, 1'b0);
        push_beat(32'h0, 4, 1'b1);
        drain();
        push_message(15, 4);
        push_message(15, 0);
        push_message(13, 2);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            for (int k = 0; k < NumChain; k++) begin
                case (phase % 4)
                    0: write_init(k, 32'h0);
                    1: write_init(k, 32'hffffffff);
                    2: write_init(k, $urandom());
                    default: write_init(k, InitReset[k]);
                endcase
            end
            for (int m = 0; m < 4; m++) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 40)
                                                  : $urandom_range(0, 8);
                push_message(len, $urandom_range(0, 7));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### sha256_stream_hasher.f
rtl/sha_pkg.sv
rtl/sha_sched_cell.sv
rtl/sha_sched.sv
rtl/sha256_stream_hasher.sv
dv/sha256_stream_hasher_tb.sv
